/* rtl/pac_pkg.sv */
// Shared types, field widths and operation codes for the priority channel allocator.
// Used by the controller, the datapath, the top level and the port checker.
package pac_pkg;

  // Default sizing handed down from the top level, and the active count after reset
  localparam int unsigned CHANNELS_DEF    = 16;
  localparam int unsigned SOURCE_BITS_DEF = 16;
  localparam int unsigned RESET_ACTIVE    = 16;

  // Fixed port field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned PRI_W    = 8;
  localparam int unsigned SRC_IN_W = 16;
  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned ACT_IN_W = 5;
  localparam int unsigned STAT_W   = 2;

  // Operation codes on func
  localparam logic [FUNC_W-1:0] FUNC_ALLOC     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE_CHAN = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FREE_SRC  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FREE_ALL  = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_GRANT_FREE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_GRANT_EVICT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_REFUSED     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_STOP_DONE   = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // latch the request beat and start the table read
    logic step;    // evaluate one table entry
    logic finish;  // commit table updates and register the result
  } pac_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic active_zero;  // no channel takes part
    logic scan_last;    // entry under evaluation is the last active one
  } pac_sts_t;

endpackage

/* rtl/priority_channel_allocator_top.sv */
// Top level of the priority channel allocator: controller plus datapath.
// Depends on pac_pkg, pac_ctrl and pac_datapath.
//
// Issue a request with start_i while busy_o is low; the result beat appears on the
// result ports for exactly one cycle with done_o high and cannot be held off, so
// the receiver must take it in that cycle. Freeing one channel needs no table scan:
// the accept moves the controller straight to its finish state, from which done_o is
// registered. Allocate, free by source and free all walk the channel table one
// entry per cycle through its single registered read port, then pass the finish
// state; with active_channels at zero the scan is skipped.
// A new request may be issued in the cycle in which done_o is high.
// Writing active_channels takes effect at once and frees every channel at or above
// the new count; write it only while no request is in flight.
module priority_channel_allocator_top #(
  parameter int unsigned CHANNELS    = pac_pkg::CHANNELS_DEF,
  parameter int unsigned SOURCE_BITS = pac_pkg::SOURCE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pac_pkg::ACT_IN_W-1:0]  cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [pac_pkg::FUNC_W-1:0]    func_i,
  input  logic [pac_pkg::PRI_W-1:0]     priority_req_i,
  input  logic [pac_pkg::SRC_IN_W-1:0]  source_id_i,
  input  logic [pac_pkg::CHAN_W-1:0]    channel_i,
  output logic                          done_o,
  output logic [pac_pkg::STAT_W-1:0]    status_o,
  output logic [pac_pkg::CHAN_W-1:0]    granted_channel_o,
  output logic                          displaced_valid_o,
  output logic [pac_pkg::CHAN_W-1:0]    displaced_channel_o,
  output logic [pac_pkg::CNT_W-1:0]     stopped_count_o
);
  import pac_pkg::*;

  pac_cmd_t cmd;
  pac_sts_t sts;

  // Sequence the scan
  pac_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (func_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Hold the table and build the result
  pac_datapath #(
    .CHANNELS    (CHANNELS),
    .SOURCE_BITS (SOURCE_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .func_i              (func_i),
    .priority_req_i      (priority_req_i),
    .source_id_i         (source_id_i),
    .channel_i           (channel_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .done_o              (done_o),
    .status_o            (status_o),
    .granted_channel_o   (granted_channel_o),
    .displaced_valid_o   (displaced_valid_o),
    .displaced_channel_o (displaced_channel_o),
    .stopped_count_o     (stopped_count_o)
  );

endmodule

/* rtl/pac_ctrl.sv */
// Sequencing state machine of the priority channel allocator.
// Depends on pac_pkg for the command and status structs and the func codes.
module pac_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pac_pkg::FUNC_W-1:0]   func_i,
  input  pac_pkg::pac_sts_t            sts_i,
  output pac_pkg::pac_cmd_t            cmd_o,
  output logic                         busy_o
);
  import pac_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          // a single-channel free and a zero active count need no scan
          if (func_i == FUNC_FREE_CHAN || sts_i.active_zero) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

/* rtl/pac_datapath.sv */
// Channel table, scan trackers and result registers of the priority channel allocator.
// Depends on pac_pkg; driven by pac_ctrl through the command struct.
module pac_datapath #(
  parameter int unsigned CHANNELS    = pac_pkg::CHANNELS_DEF,
  parameter int unsigned SOURCE_BITS = pac_pkg::SOURCE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pac_pkg::ACT_IN_W-1:0]  cfg_wdata_i,
  input  logic [pac_pkg::FUNC_W-1:0]    func_i,
  input  logic [pac_pkg::PRI_W-1:0]     priority_req_i,
  input  logic [pac_pkg::SRC_IN_W-1:0]  source_id_i,
  input  logic [pac_pkg::CHAN_W-1:0]    channel_i,
  input  pac_pkg::pac_cmd_t             cmd_i,
  output pac_pkg::pac_sts_t             sts_o,
  output logic                          done_o,
  output logic [pac_pkg::STAT_W-1:0]    status_o,
  output logic [pac_pkg::CHAN_W-1:0]    granted_channel_o,
  output logic                          displaced_valid_o,
  output logic [pac_pkg::CHAN_W-1:0]    displaced_channel_o,
  output logic [pac_pkg::CNT_W-1:0]     stopped_count_o
);
  import pac_pkg::*;

  localparam int unsigned IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned ACT_W  = $clog2(CHANNELS + 1);
  localparam int unsigned CFG_CW = (ACT_W > ACT_IN_W) ? ACT_W : ACT_IN_W;
  localparam int unsigned CHN_CW = (ACT_W > CHAN_W) ? ACT_W : CHAN_W;
  localparam logic [ACT_W-1:0] ACT_RESET =
    (RESET_ACTIVE > CHANNELS) ? ACT_W'(CHANNELS) : ACT_W'(RESET_ACTIVE);

  // Configuration and occupancy
  logic [ACT_W-1:0]    active_q, active_new;
  logic [CHANNELS-1:0] occ_q, occ_d, keep_mask;

  // Latched request beat
  logic [FUNC_W-1:0]      func_q;
  logic [PRI_W-1:0]       pri_q;
  logic [SOURCE_BITS-1:0] src_q;
  logic [CHAN_W-1:0]      chn_q;

  // Scan position and trackers
  logic [IDX_W-1:0] idx_q, rd_addr;
  logic             cand_found_q, match_found_q, min_valid_q;
  logic [IDX_W-1:0] cand_idx_q, match_idx_q, min_idx_q;
  logic [PRI_W-1:0] min_pri_q;
  logic [ACT_W-1:0] count_q;

  // Channel table memories
  logic [PRI_W-1:0]       pri_mem [CHANNELS];
  logic [SOURCE_BITS-1:0] src_mem [CHANNELS];
  logic [PRI_W-1:0]       rd_pri_q;
  logic [SOURCE_BITS-1:0] rd_src_q;
  logic                   mem_we;
  logic [IDX_W-1:0]       wr_idx;

  // Per-entry evaluation
  logic cur_occ, match_hit, free_all_hit;

  // Finish decisions and result values
  logic             chn_ok, grant_free, grant_evict;
  logic [IDX_W-1:0] chn_idx;
  logic [STAT_W-1:0] res_status;
  logic [IDX_W-1:0] res_grant, res_disp;
  logic             res_disp_v;
  logic [ACT_W-1:0] res_cnt;

  // Clamp a written active count and find the channels it keeps
  always_comb begin
    if (CFG_CW'(cfg_wdata_i) > CFG_CW'(CHANNELS)) begin
      active_new = ACT_W'(CHANNELS);
    end else begin
      active_new = ACT_W'(cfg_wdata_i);
    end
    for (int i = 0; i < CHANNELS; i++) begin
      keep_mask[i] = (ACT_W'(i) < active_new);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACT_RESET;
    end else if (cfg_we_i) begin
      active_q <= active_new;
    end
  end

  // Evaluate the entry whose table data was read last cycle
  assign cur_occ      = occ_q[idx_q];
  assign match_hit    = cur_occ && (|src_q) && (rd_src_q == src_q);
  assign free_all_hit = (func_q == FUNC_FREE_ALL) && cur_occ && (|rd_src_q);

  assign sts_o.active_zero = (active_q == '0);
  assign sts_o.scan_last   = ((ACT_W'(idx_q) + ACT_W'(1)) == active_q);

  // Read the first entry on load, the following entry on each step
  assign rd_addr = cmd_i.load ? '0 : idx_q + IDX_W'(1);

  // Advance the scan and update the trackers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q        <= FUNC_ALLOC;
      idx_q         <= '0;
      cand_found_q  <= 1'b0;
      match_found_q <= 1'b0;
      min_valid_q   <= 1'b0;
      count_q       <= '0;
    end else if (cmd_i.load) begin
      func_q        <= func_i;
      idx_q         <= '0;
      cand_found_q  <= 1'b0;
      match_found_q <= 1'b0;
      min_valid_q   <= 1'b0;
      count_q       <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + IDX_W'(1);
      if (!match_found_q && match_hit) begin
        match_found_q <= 1'b1;
      end
      if (!cand_found_q && (!cur_occ || match_hit)) begin
        cand_found_q <= 1'b1;
      end
      if (cur_occ && (!min_valid_q || rd_pri_q < min_pri_q)) begin
        min_valid_q <= 1'b1;
      end
      if (free_all_hit) begin
        count_q <= count_q + ACT_W'(1);
      end
    end
  end

  // Payload side of the request latch and trackers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pri_q <= priority_req_i;
      src_q <= SOURCE_BITS'(source_id_i);
      chn_q <= channel_i;
    end else if (cmd_i.step) begin
      if (!match_found_q && match_hit) begin
        match_idx_q <= idx_q;
      end
      if (!cand_found_q && (!cur_occ || match_hit)) begin
        cand_idx_q <= idx_q;
      end
      if (cur_occ && (!min_valid_q || rd_pri_q < min_pri_q)) begin
        min_pri_q <= rd_pri_q;
        min_idx_q <= idx_q;
      end
    end
  end

  // Decide the outcome of the item
  assign chn_ok      = (CHN_CW'(chn_q) < CHN_CW'(active_q)) && occ_q[chn_idx];
  assign chn_idx     = IDX_W'(chn_q);
  assign grant_free  = (func_q == FUNC_ALLOC) && cand_found_q;
  assign grant_evict = (func_q == FUNC_ALLOC) && !cand_found_q && min_valid_q &&
                       (pri_q > min_pri_q);

  always_comb begin
    res_status = STAT_STOP_DONE;
    res_grant  = '0;
    res_disp_v = 1'b0;
    res_disp   = '0;
    res_cnt    = '0;
    wr_idx     = cand_idx_q;
    unique case (func_q)
      FUNC_ALLOC: begin
        if (grant_free) begin
          res_status = STAT_GRANT_FREE;
          res_grant  = cand_idx_q;
          if (match_found_q) begin
            res_disp_v = 1'b1;
            res_disp   = match_idx_q;
            res_cnt    = ACT_W'(1);
          end
        end else if (grant_evict) begin
          res_status = STAT_GRANT_EVICT;
          res_grant  = min_idx_q;
          res_disp_v = 1'b1;
          res_disp   = min_idx_q;
          res_cnt    = ACT_W'(1);
          wr_idx     = min_idx_q;
        end else begin
          res_status = STAT_REFUSED;
        end
      end
      FUNC_FREE_CHAN: begin
        if (chn_ok) begin
          res_cnt = ACT_W'(1);
        end
      end
      FUNC_FREE_SRC: begin
        if (match_found_q) begin
          res_cnt = ACT_W'(1);
        end
      end
      FUNC_FREE_ALL: begin
        res_cnt = count_q;
      end
    endcase
  end

  assign mem_we = cmd_i.finish && (grant_free || grant_evict);

  // Next occupancy: config clear, free-all during the scan, commit on finish
  always_comb begin
    occ_d = occ_q;
    if (cfg_we_i) begin
      occ_d = occ_d & keep_mask;
    end
    if (cmd_i.step && free_all_hit) begin
      occ_d[idx_q] = 1'b0;
    end
    if (cmd_i.finish) begin
      unique case (func_q)
        FUNC_ALLOC: begin
          // drop the same-source channel before marking the grant
          if (grant_free && match_found_q) begin
            occ_d[match_idx_q] = 1'b0;
          end
          if (grant_free || grant_evict) begin
            occ_d[wr_idx] = 1'b1;
          end
        end
        FUNC_FREE_CHAN: begin
          if (chn_ok) begin
            occ_d[chn_idx] = 1'b0;
          end
        end
        FUNC_FREE_SRC: begin
          if (match_found_q) begin
            occ_d[match_idx_q] = 1'b0;
          end
        end
        FUNC_FREE_ALL: begin
          occ_d = occ_d;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Channel table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pri_mem[wr_idx] <= pri_q;
      src_mem[wr_idx] <= src_q;
    end
    rd_pri_q <= pri_mem[rd_addr];
    rd_src_q <= src_mem[rd_addr];
  end

  // Result beat: strobe for one cycle after finish
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_o            <= res_status;
      granted_channel_o   <= CHAN_W'(res_grant);
      displaced_valid_o   <= res_disp_v;
      displaced_channel_o <= CHAN_W'(res_disp);
      stopped_count_o     <= CNT_W'(res_cnt);
    end
  end

endmodule

/* rtl/pac_checker.sv */
// Port-level checks of the priority channel allocator, bound to the top level.
// Depends on pac_pkg for the status codes.
module pac_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        done_o,
  input logic [pac_pkg::STAT_W-1:0]  status_o,
  input logic [pac_pkg::CHAN_W-1:0]  granted_channel_o,
  input logic                        displaced_valid_o,
  input logic [pac_pkg::CNT_W-1:0]   stopped_count_o
);
  import pac_pkg::*;

  // An accepted beat keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not raise busy");

  // The result strobe lasts one cycle and the block is free while it shows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy_o ##1 !done_o))
    else $error("result strobe longer than one cycle or shown while busy");

  // A refusal grants nothing and frees nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_REFUSED) |->
      (granted_channel_o == '0 && !displaced_valid_o && stopped_count_o == '0))
    else $error("refused allocate reports a grant or a freed channel");

  // Stop operations never report a grant or a displaced channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_STOP_DONE) |->
      (granted_channel_o == '0 && !displaced_valid_o))
    else $error("stop operation reports allocate fields");

  // A displaced channel is counted as freed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && displaced_valid_o) |-> (stopped_count_o == CNT_W'(1)))
    else $error("displaced channel not counted");

endmodule

bind priority_channel_allocator_top pac_checker u_pac_checker (.*);
